### design/method_descriptor_parser_macros.svh
// Assertion helpers shared by the descriptor parser RTL.
// Each expects clk and rst_n in scope.
`ifndef METHOD_DESCRIPTOR_PARSER_MACROS_SVH
`define METHOD_DESCRIPTOR_PARSER_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define MDP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MDP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mdp_pkg.sv
package mdp_pkg;

    typedef enum logic [3:0] {
        PH_OPEN        = 4'd0,
        PH_PARAM       = 4'd1,
        PH_PARAM_ARR   = 4'd2,
        PH_PARAM_NAME0 = 4'd3,
        PH_PARAM_NAME  = 4'd4,
        PH_RET         = 4'd5,
        PH_RET_ARR     = 4'd6,
        PH_RET_NAME0   = 4'd7,
        PH_RET_NAME    = 4'd8,
        PH_DONE        = 4'd9,
        PH_ERROR       = 4'd10
    } phase_t;

    // descriptor characters
    localparam logic [7:0] CH_OPEN  = 8'h28; // (
    localparam logic [7:0] CH_CLOSE = 8'h29; // )
    localparam logic [7:0] CH_VOID  = 8'h56; // V
    localparam logic [7:0] CH_CLASS = 8'h4C; // L
    localparam logic [7:0] CH_ARRAY = 8'h5B; // [
    localparam logic [7:0] CH_SEMI  = 8'h3B; // ;
    localparam logic [7:0] CH_DOT   = 8'h2E; // .
    localparam logic [7:0] CH_BOOL  = 8'h5A; // Z
    localparam logic [7:0] CH_BYTE  = 8'h42; // B
    localparam logic [7:0] CH_CHAR  = 8'h43; // C
    localparam logic [7:0] CH_SHORT = 8'h53; // S
    localparam logic [7:0] CH_INT   = 8'h49; // I
    localparam logic [7:0] CH_LONG  = 8'h4A; // J
    localparam logic [7:0] CH_FLOAT = 8'h46; // F
    localparam logic [7:0] CH_DBL   = 8'h44; // D

    // parameter kinds
    localparam logic [3:0] KIND_OBJECT = 4'd0;
    localparam logic [3:0] KIND_BOOL   = 4'd1;
    localparam logic [3:0] KIND_BYTE   = 4'd2;
    localparam logic [3:0] KIND_CHAR   = 4'd3;
    localparam logic [3:0] KIND_SHORT  = 4'd4;
    localparam logic [3:0] KIND_INT    = 4'd5;
    localparam logic [3:0] KIND_LONG   = 4'd6;
    localparam logic [3:0] KIND_FLOAT  = 4'd7;
    localparam logic [3:0] KIND_DOUBLE = 4'd8;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic       is_final;
        logic [3:0] param_kind;
        logic [7:0] param_position;
        logic       accepted;
        logic [7:0] param_total;
        logic       run_last;
    } result_t;

    typedef struct packed {
        phase_t     next_phase;
        logic [7:0] next_count;
        logic [1:0] n_results;
        result_t    res0;
        result_t    res1;
    } step_t;

    // primitive letter to kind, KIND_OBJECT when not a primitive
    function automatic logic [3:0] prim_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_BOOL:  k = KIND_BOOL;
            CH_BYTE:  k = KIND_BYTE;
            CH_CHAR:  k = KIND_CHAR;
            CH_SHORT: k = KIND_SHORT;
            CH_INT:   k = KIND_INT;
            CH_LONG:  k = KIND_LONG;
            CH_FLOAT: k = KIND_FLOAT;
            CH_DBL:   k = KIND_DOUBLE;
            default:  k = KIND_OBJECT;
        endcase
        return k;
    endfunction

endpackage

### design/mdp_char_if.sv
interface mdp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_text;

    modport source (output valid, output character, output end_of_text, input ready);
    modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

### design/mdp_result_if.sv
interface mdp_result_if;
    logic       valid;
    logic       ready;
    logic       is_final;
    logic [3:0] param_kind;
    logic [7:0] param_position;
    logic       accepted;
    logic [7:0] param_total;
    logic       run_last;

    modport source (
        output valid, output is_final, output param_kind, output param_position,
        output accepted, output param_total, output run_last, input ready
    );
    modport sink (
        input valid, input is_final, input param_kind, input param_position,
        input accepted, input param_total, input run_last, output ready
    );
endinterface

### design/mdp_step.sv
module mdp_step
    import mdp_pkg::*;
(
    input  phase_t     phase,
    input  logic [7:0] count,
    input  logic [7:0] character,
    input  logic       end_of_text,
    output step_t      step
);

    logic [3:0] pk;
    phase_t     nxt;
    logic       emit;
    logic [3:0] kind;
    logic       forbidden;
    logic [7:0] counted;
    result_t    param_res;
    result_t    status_res;

    assign pk        = prim_kind(character);
    assign forbidden = character inside {CH_ARRAY, CH_OPEN, CH_CLOSE, CH_DOT};

    always_comb
    begin
        nxt  = PH_ERROR;
        emit = 1'b0;
        kind = KIND_OBJECT;
        case (phase)
            PH_OPEN:
            begin
                nxt = (character == CH_OPEN) ? PH_PARAM : PH_ERROR;
            end
            PH_PARAM, PH_PARAM_ARR:
            begin
                if (phase == PH_PARAM && character == CH_CLOSE)
                begin
                    nxt = PH_RET;
                end
                else if (pk != KIND_OBJECT)
                begin
                    emit = 1'b1;
                    kind = (phase == PH_PARAM) ? pk : KIND_OBJECT; // arrays as object
                    nxt  = PH_PARAM;
                end
                else if (character == CH_CLASS)
                begin
                    nxt = PH_PARAM_NAME0;
                end
                else if (character == CH_ARRAY)
                begin
                    nxt = PH_PARAM_ARR;
                end
            end
            PH_PARAM_NAME0, PH_PARAM_NAME:
            begin
                if (character == CH_SEMI)
                begin
                    if (phase == PH_PARAM_NAME)
                    begin
                        emit = 1'b1;
                        nxt  = PH_PARAM;
                    end
                end
                else if (!forbidden)
                begin
                    nxt = PH_PARAM_NAME;
                end
            end
            PH_RET, PH_RET_ARR:
            begin
                if (pk != KIND_OBJECT || (phase == PH_RET && character == CH_VOID))
                begin
                    nxt = PH_DONE;
                end
                else if (character == CH_CLASS)
                begin
                    nxt = PH_RET_NAME0;
                end
                else if (character == CH_ARRAY)
                begin
                    nxt = PH_RET_ARR;
                end
            end
            PH_RET_NAME0, PH_RET_NAME:
            begin
                if (character == CH_SEMI)
                begin
                    if (phase == PH_RET_NAME)
                    begin
                        nxt = PH_DONE;
                    end
                end
                else if (!forbidden)
                begin
                    nxt = PH_RET_NAME;
                end
            end
            default:
            begin
                nxt = PH_ERROR; // done, error and unused codes: any byte fails
            end
        endcase
    end

    // saturating count
    assign counted = (emit && count != COUNT_MAX) ? count + 8'd1 : count;

    always_comb
    begin
        param_res                = '0;
        param_res.param_kind     = kind;
        param_res.param_position = count;
        param_res.run_last       = !end_of_text;

        status_res             = '0;
        status_res.is_final    = 1'b1;
        status_res.accepted    = (nxt == PH_DONE);
        status_res.param_total = counted;
        status_res.run_last    = 1'b1;

        step.next_phase = end_of_text ? PH_OPEN : nxt;
        step.next_count = end_of_text ? 8'd0 : counted;
        step.n_results  = {1'b0, emit} + {1'b0, end_of_text};
        step.res0       = emit ? param_res : status_res;
        step.res1       = status_res;
    end

endmodule

### design/mdp_queue.sv
module mdp_queue
    import mdp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_n,
    input  result_t             push0,
    input  result_t             push1,
    output logic                room,
    mdp_result_if.source        result
);

    `include "method_descriptor_parser_macros.svh"

    result_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [Q_PTR_W-1:0]   wr_ptr_plus1;
    logic                 pop;
    result_t              head;

    // room for a two-result byte even without a pop this cycle
    assign room         = count_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign pop          = result.valid && result.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + Q_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + Q_PTR_W'(push_n);
    assign rd_ptr_next  = rd_ptr_reg + Q_PTR_W'(pop);
    assign count_next   = count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

    assign head                  = entry_reg[rd_ptr_reg];
    assign result.valid          = count_reg != '0;
    assign result.is_final       = head.is_final;
    assign result.param_kind     = head.param_kind;
    assign result.param_position = head.param_position;
    assign result.accepted       = head.accepted;
    assign result.param_total    = head.param_total;
    assign result.run_last       = head.run_last;

    `MDP_ASSERT_ALWAYS(a_q_bound, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count beyond depth")
    `MDP_ASSERT_IMPL(a_q_push_room, push_n != 2'd0, room, "push into a full queue")
    `MDP_ASSERT_IMPL(a_q_ptrs, count_reg != Q_CNT_W'(Q_DEPTH),
        (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0], "queue pointers out of step")

endmodule

### design/method_descriptor_parser.sv
// Method descriptor parser.
// desc (mdp_char_if sink): one descriptor byte per transaction, with
//   end_of_text set on the final byte of each descriptor.
// result (mdp_result_if source): one result per transaction. A finished
//   parameter gives a parameter result (kind, position); the final byte
//   also gives a status result (accepted, param_total) after any
//   parameter result it completes. run_last marks the last result of a
//   byte. Results of a rejected descriptor are to be discarded.
// A byte's results are registered in the result queue when it is accepted and are offered in order from its head.
// Throughput: one byte per cycle while results drain at the same pace;
//   the final byte that also closes a parameter gives two results.
//   The four-entry result queue sets this: desc.ready is high while at
//   most two results are queued.
// Reset: parser returns to expecting '(' with a zero count, queue empties.
// Receiver stall: queued results hold; once three or more are waiting,
//   desc.ready drops until at most two remain.
// After the final byte the parser is back in its reset state, so the
//   next descriptor may follow in the next cycle.
module method_descriptor_parser
    import mdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mdp_char_if.sink     desc,
    mdp_result_if.source result
);

    `include "method_descriptor_parser_macros.svh"

    phase_t     phase_reg;
    logic [7:0] count_reg;
    step_t      step;
    logic       accept;
    logic       room;
    logic [1:0] push_n;

    // grammar step on the incoming byte
    mdp_step u_step (
        .phase       (phase_reg),
        .count       (count_reg),
        .character   (desc.character),
        .end_of_text (desc.end_of_text),
        .step        (step)
    );

    assign desc.ready = room;
    assign accept     = desc.valid && room;
    assign push_n     = accept ? step.n_results : 2'd0;

    // parser state: phase and saturating parameter count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= step.next_phase;
            count_reg <= step.next_count;
        end
    end

    // results wait here until the receiver takes them
    mdp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .push0  (step.res0),
        .push1  (step.res1),
        .room   (room),
        .result (result)
    );

    `MDP_ASSERT_NEXT(a_restart, accept && desc.end_of_text,
        phase_reg == PH_OPEN && count_reg == 8'd0, "parser not rearmed after last byte")
    `MDP_ASSERT_IMPL(a_status_form, result.valid && result.is_final,
        result.run_last && result.param_kind == KIND_OBJECT && result.param_position == 8'd0,
        "malformed status result")
    `MDP_ASSERT_IMPL(a_param_form, result.valid && !result.is_final,
        !result.accepted && result.param_total == 8'd0, "malformed parameter result")

endmodule
